// ===== rtl/hsv2rgb_pkg.sv =====
// Shared types, formats and helpers for the HSV to RGB converter.
package hsv2rgb_pkg;

    localparam int HUE_BITS     = 16;
    localparam int CH_FRAC_BITS = 14;
    localparam int IN_W         = CH_FRAC_BITS + 2;
    localparam int OUT_W        = CH_FRAC_BITS + 1;
    localparam int K_W          = HUE_BITS + 3;
    localparam int F_W          = HUE_BITS + 1;
    localparam int SECT_W       = K_W - HUE_BITS;

    localparam logic [IN_W-1:0] CH_ONE_IN = IN_W'(1) << CH_FRAC_BITS;

    typedef enum logic [SECT_W-1:0] {
        SECT_RED_YEL = 3'd0,
        SECT_YEL_GRN = 3'd1,
        SECT_GRN_CYN = 3'd2,
        SECT_CYN_BLU = 3'd3,
        SECT_BLU_MAG = 3'd4,
        SECT_MAG_RED = 3'd5
    } sector_t;

    typedef struct packed {
        logic [HUE_BITS-1:0]    hue;
        logic signed [IN_W-1:0] saturation;
        logic signed [IN_W-1:0] value;
    } pix_t;

    typedef struct packed {
        logic [OUT_W-1:0] red;
        logic [OUT_W-1:0] green;
        logic [OUT_W-1:0] blue;
    } rgb_t;

    typedef struct packed {
        sector_t          sector;
        logic [F_W-1:0]   tent;
        logic [OUT_W-1:0] sat;
        logic [OUT_W-1:0] val;
    } prep_t;

    typedef struct packed {
        sector_t          sector;
        logic [F_W-1:0]   tent;
        logic [OUT_W-1:0] chroma;
        logic [OUT_W-1:0] val;
    } chroma_t;

    typedef struct packed {
        sector_t          sector;
        logic [OUT_W-1:0] x;
        logic [OUT_W-1:0] chroma;
        logic [OUT_W-1:0] base;
    } mix_t;

    // Load enables of the four pipeline stages.
    typedef struct packed {
        logic prep;
        logic chroma;
        logic tent;
        logic mix;
    } adv_t;

    function automatic logic [OUT_W-1:0] clamp_unit(input logic signed [IN_W-1:0] raw);
        logic [OUT_W-1:0] res;
        if (raw[IN_W-1])
            res = '0;
        else if ($unsigned(raw) > CH_ONE_IN)
            res = CH_ONE_IN[OUT_W-1:0];
        else
            res = raw[OUT_W-1:0];
        return res;
    endfunction

endpackage

// ===== rtl/hsv2rgb_prep.sv =====
// Stage 1: clamp saturation and value, split 6h into sector and tent factor.
module hsv2rgb_prep
    import hsv2rgb_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  load,
    input  logic  valid_in,
    input  pix_t  pix_in,
    output logic  valid_reg,
    output prep_t data_reg
);

    logic [K_W-1:0]    k;
    logic [HUE_BITS:0] km2;
    prep_t             data_next;

    always_comb
    begin
        k   = (K_W'(pix_in.hue) << 2) + (K_W'(pix_in.hue) << 1);
        km2 = k[HUE_BITS:0];
        data_next.sector = sector_t'(k[K_W-1:HUE_BITS]);
        // Fold the falling half of the tent: f = 2 - (6h mod 2) there.
        data_next.tent   = km2[HUE_BITS] ? (F_W'(0) - km2) : km2;
        data_next.sat    = clamp_unit(pix_in.saturation);
        data_next.val    = clamp_unit(pix_in.value);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (load && valid_in)
            data_reg <= data_next;
    end

endmodule

// ===== rtl/hsv2rgb_chroma.sv =====
// Stages 2 and 3: chroma product, then the X product and the grey offset.
module hsv2rgb_chroma
    import hsv2rgb_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  adv_t    adv,
    input  logic    valid_in,
    input  prep_t   prep_in,
    output logic    chroma_valid_reg,
    output logic    mix_valid_reg,
    output mix_t    mix_reg
);

    chroma_t                 chroma_reg;
    chroma_t                 chroma_next;
    mix_t                    mix_next;
    logic [2*OUT_W-1:0]      prod_cv;
    logic [OUT_W+F_W-1:0]    prod_x;

    always_comb
    begin
        prod_cv = (2*OUT_W)'(prep_in.sat) * (2*OUT_W)'(prep_in.val);
        chroma_next.sector = prep_in.sector;
        chroma_next.tent   = prep_in.tent;
        chroma_next.chroma = prod_cv[CH_FRAC_BITS +: OUT_W];
        chroma_next.val    = prep_in.val;
    end

    always_comb
    begin
        prod_x = (OUT_W+F_W)'(chroma_reg.chroma) * (OUT_W+F_W)'(chroma_reg.tent);
        mix_next.sector = chroma_reg.sector;
        mix_next.x      = prod_x[HUE_BITS +: OUT_W];
        mix_next.chroma = chroma_reg.chroma;
        mix_next.base   = chroma_reg.val - chroma_reg.chroma;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chroma_valid_reg <= 1'b0;
            mix_valid_reg    <= 1'b0;
        end
        else
        begin
            if (adv.chroma)
                chroma_valid_reg <= valid_in;
            if (adv.tent)
                mix_valid_reg <= chroma_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.chroma && valid_in)
            chroma_reg <= chroma_next;
        if (adv.tent && chroma_valid_reg)
            mix_reg <= mix_next;
    end

endmodule

// ===== rtl/hsv2rgb_mix.sv =====
// Stage 4: place chroma, X and zero by sector and add the grey offset.
module hsv2rgb_mix
    import hsv2rgb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic load,
    input  logic valid_in,
    input  mix_t mix_in,
    output logic valid_reg,
    output rgb_t rgb_reg
);

    logic [OUT_W-1:0] r_sel;
    logic [OUT_W-1:0] g_sel;
    logic [OUT_W-1:0] b_sel;
    rgb_t             rgb_next;

    always_comb
    begin
        case (mix_in.sector)
            SECT_RED_YEL: begin r_sel = mix_in.chroma; g_sel = mix_in.x;      b_sel = '0;            end
            SECT_YEL_GRN: begin r_sel = mix_in.x;      g_sel = mix_in.chroma; b_sel = '0;            end
            SECT_GRN_CYN: begin r_sel = '0;            g_sel = mix_in.chroma; b_sel = mix_in.x;      end
            SECT_CYN_BLU: begin r_sel = '0;            g_sel = mix_in.x;      b_sel = mix_in.chroma; end
            SECT_BLU_MAG: begin r_sel = mix_in.x;      g_sel = '0;            b_sel = mix_in.chroma; end
            default:      begin r_sel = mix_in.chroma; g_sel = '0;            b_sel = mix_in.x;      end
        endcase
        rgb_next.red   = r_sel + mix_in.base;
        rgb_next.green = g_sel + mix_in.base;
        rgb_next.blue  = b_sel + mix_in.base;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (load && valid_in)
            rgb_reg <= rgb_next;
    end

endmodule

// ===== rtl/hsv_to_rgb_converter_core.sv =====
// Top level of the pipelined HSV to RGB converter.
//
//  channel | signals                        | payload
//  --------+--------------------------------+------------------------------
//  input   | pix_valid, pix_ready, pix      | hue, saturation, value
//  output  | rgb_valid, rgb_ready, rgb      | red, green, blue
//
// One pixel per clock while the output is not stalled; each pixel passes
// through clamp/sector, chroma multiply, X multiply and channel mix.
// Reset empties the pipeline; no payload register is cleared.
// A stall at the output holds only stages that are full; bubbles close up,
// so pix_ready stays high while any stage is empty.
module hsv_to_rgb_converter_core
    import hsv2rgb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic pix_valid,
    output logic pix_ready,
    input  pix_t pix,
    output logic rgb_valid,
    input  logic rgb_ready,
    output rgb_t rgb
);

    adv_t  adv;
    logic  prep_valid;
    prep_t prep_data;
    logic  chroma_valid;
    logic  mix_valid;
    mix_t  mix_data;

    // Advance a stage when it is empty or its successor advances.
    always_comb
    begin
        adv.mix    = !rgb_valid || rgb_ready;
        adv.tent   = !mix_valid || adv.mix;
        adv.chroma = !chroma_valid || adv.tent;
        adv.prep   = !prep_valid || adv.chroma;
    end

    assign pix_ready = adv.prep;

    hsv2rgb_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (adv.prep),
        .valid_in  (pix_valid),
        .pix_in    (pix),
        .valid_reg (prep_valid),
        .data_reg  (prep_data)
    );

    hsv2rgb_chroma u_chroma (
        .clk              (clk),
        .rst_n            (rst_n),
        .adv              (adv),
        .valid_in         (prep_valid),
        .prep_in          (prep_data),
        .chroma_valid_reg (chroma_valid),
        .mix_valid_reg    (mix_valid),
        .mix_reg          (mix_data)
    );

    hsv2rgb_mix u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (adv.mix),
        .valid_in  (mix_valid),
        .mix_in    (mix_data),
        .valid_reg (rgb_valid),
        .rgb_reg   (rgb)
    );

endmodule

// ===== rtl/hsv2rgb_checker.sv =====
// Port-level assertions for the HSV to RGB converter, bound to the top level.
module hsv2rgb_checker
    import hsv2rgb_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic pix_valid,
    input logic pix_ready,
    input pix_t pix,
    input logic rgb_valid,
    input logic rgb_ready,
    input rgb_t rgb
);

    localparam logic [OUT_W-1:0] CH_ONE = OUT_W'(1) << CH_FRAC_BITS;

    logic             pix_xfer;
    logic             flow4;
    logic [OUT_W-1:0] val_clamped;
    logic [3:0]       xfer_hist_reg;
    logic [2:0]       ready_hist_reg;

    assign pix_xfer    = pix_valid && pix_ready;
    assign val_clamped = clamp_unit(pix.value);

    // Shift in input transfers and output ready levels, one bit per edge.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xfer_hist_reg  <= '0;
            ready_hist_reg <= '0;
        end
        else
        begin
            xfer_hist_reg  <= {xfer_hist_reg[2:0], pix_xfer};
            ready_hist_reg <= {ready_hist_reg[1:0], rgb_ready};
        end
    end

    // Input transfer in the oldest history bit, output ready at every edge since.
    assign flow4 = xfer_hist_reg[3] && (&ready_hist_reg);

    a_rgb_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rgb_valid && !rgb_ready |=> rgb_valid && $stable(rgb))
        else $error("result dropped or changed while stalled");

    a_rgb_range: assert property (@(posedge clk) disable iff (!rst_n)
        rgb_valid |-> rgb.red <= CH_ONE && rgb.green <= CH_ONE && rgb.blue <= CH_ONE)
        else $error("channel above full intensity");

    a_grey: assert property (@(posedge clk) disable iff (!rst_n)
        flow4 && $past(pix.saturation[IN_W-1], 4)
        |-> rgb_valid && rgb.red == rgb.green && rgb.green == rgb.blue)
        else $error("zero saturation did not give grey after four cycles");

    a_max_is_value: assert property (@(posedge clk) disable iff (!rst_n)
        flow4 |-> rgb_valid && (rgb.red == $past(val_clamped, 4)
                                || rgb.green == $past(val_clamped, 4)
                                || rgb.blue == $past(val_clamped, 4)))
        else $error("no channel carries the clamped value");

endmodule

bind hsv_to_rgb_converter_core hsv2rgb_checker u_hsv2rgb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix       (pix),
    .rgb_valid (rgb_valid),
    .rgb_ready (rgb_ready),
    .rgb       (rgb)
);
